/* rtl/idea_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the IDEA round with tap output.
package idea_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned NumStages = 7;

  typedef logic [WordW-1:0] word_t;
  typedef logic [2*WordW-1:0] dword_t;

  typedef enum logic [1:0] {
    TAP_FULL = 2'd0,
    TAP_PROD = 2'd1,
    TAP_MA1  = 2'd2,
    TAP_MA2  = 2'd3
  } tap_sel_e;

endpackage

/* rtl/idea_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for input blocks and round results.
interface idea_in_if;
  logic                valid;
  logic                ready;
  idea_pkg::tap_sel_e  func;
  idea_pkg::word_t     x_one;
  idea_pkg::word_t     x_two;
  idea_pkg::word_t     x_three;
  idea_pkg::word_t     x_four;
  idea_pkg::word_t     k_one;
  idea_pkg::word_t     k_two;
  idea_pkg::word_t     k_three;
  idea_pkg::word_t     k_four;
  idea_pkg::word_t     k_five;
  idea_pkg::word_t     k_six;

  modport source (
    output valid, func, x_one, x_two, x_three, x_four,
    output k_one, k_two, k_three, k_four, k_five, k_six,
    input  ready
  );
  modport sink (
    input  valid, func, x_one, x_two, x_three, x_four,
    input  k_one, k_two, k_three, k_four, k_five, k_six,
    output ready
  );
endinterface

interface idea_out_if;
  logic            valid;
  logic            ready;
  idea_pkg::word_t y_one;
  idea_pkg::word_t y_two;
  idea_pkg::word_t y_three;
  idea_pkg::word_t y_four;
  idea_pkg::word_t tap_word;

  modport source (
    output valid, y_one, y_two, y_three, y_four, tap_word,
    input  ready
  );
  modport sink (
    input  valid, y_one, y_two, y_three, y_four, tap_word,
    output ready
  );
endinterface

/* rtl/idea_mul.sv */
`timescale 1ns / 1ps
// Two-stage multiplier modulo 2^16+1, zero operand standing for 2^16.
module idea_mul (
  input  logic            clk_i,
  input  logic            en_a_i,
  input  logic            en_b_i,
  input  idea_pkg::word_t a_i,
  input  idea_pkg::word_t b_i,
  output idea_pkg::word_t prod_o
);

  idea_pkg::dword_t prod_d, prod_q;
  idea_pkg::word_t  alt_d, alt_q;
  logic             zero_d, zero_q;
  idea_pkg::word_t  lo, hi, res_d, res_q;

  always_comb begin
    prod_d = idea_pkg::dword_t'(a_i) * idea_pkg::dword_t'(b_i);
    zero_d = (a_i == '0) || (b_i == '0);
    // 65537 - x mod 2^16 is 1 - x
    alt_d  = (a_i == '0) ? (idea_pkg::word_t'(1) - b_i) : (idea_pkg::word_t'(1) - a_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      prod_q <= prod_d;
      zero_q <= zero_d;
      alt_q  <= alt_d;
    end
  end

  always_comb begin
    lo    = prod_q[idea_pkg::WordW-1:0];
    hi    = prod_q[2*idea_pkg::WordW-1:idea_pkg::WordW];
    res_d = zero_q ? alt_q
                   : (lo - hi + idea_pkg::word_t'(lo < hi));
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      res_q <= res_d;
    end
  end

  assign prod_o = res_q;

endmodule

/* rtl/idea_round_with_taps.sv */
`timescale 1ns / 1ps
// One IDEA round over a seven-stage pipeline, with a selectable tap word.
//
// Takes one block per clock while the output side is ready and delivers each
// result in input order. The depth comes from three modular multipliers in a
// chain (X1*K1 with X4*K4, then the two MA products), each split into a
// product stage and a reduction stage, plus one output register.
// A stall on the output fills bubbles first and then holds every stage; no
// beat is lost or repeated. The four output words always carry the full round;
// only tap_word follows func.
module idea_round_with_taps (
  input  logic           clk_i,
  input  logic           rst_ni,
  idea_in_if.sink        in_i,
  idea_out_if.source     out_o
);

  localparam int unsigned Last = idea_pkg::NumStages - 1;

  logic [idea_pkg::NumStages-1:0] v_q, v_d, en;

  idea_pkg::word_t e1, e4, t1, t2;

  // stage sideband registers
  idea_pkg::tap_sel_e s0_func_q, s1_func_q, s2_func_q, s3_func_q, s4_func_q, s5_func_q;
  idea_pkg::word_t    s0_e2_q, s0_e3_q, s0_k5_q, s0_k6_q;
  idea_pkg::word_t    s1_e2_q, s1_e3_q, s1_k5_q, s1_k6_q;
  idea_pkg::word_t    s2_e1_q, s2_e2_q, s2_e3_q, s2_e4_q, s2_k6_q;
  idea_pkg::word_t    s3_e1_q, s3_e2_q, s3_e3_q, s3_e4_q, s3_k6_q;
  idea_pkg::word_t    s4_e1_q, s4_e2_q, s4_e3_q, s4_e4_q, s4_t1_q;
  idea_pkg::word_t    s5_e1_q, s5_e2_q, s5_e3_q, s5_e4_q, s5_t1_q;
  idea_pkg::word_t    y1_q, y2_q, y3_q, y4_q, tap_q;
  idea_pkg::word_t    y1_d, y2_d, y3_d, y4_d, tap_d, u;

  always_comb begin
    en[Last] = !v_q[Last] || out_o.ready;
    for (int i = Last - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int i = 1; i < idea_pkg::NumStages; i++) begin
      v_d[i] = en[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = en[0];

  idea_mul u_mul_e1 (
    .clk_i  (clk_i),
    .en_a_i (en[0]),
    .en_b_i (en[1]),
    .a_i    (in_i.x_one),
    .b_i    (in_i.k_one),
    .prod_o (e1)
  );

  idea_mul u_mul_e4 (
    .clk_i  (clk_i),
    .en_a_i (en[0]),
    .en_b_i (en[1]),
    .a_i    (in_i.x_four),
    .b_i    (in_i.k_four),
    .prod_o (e4)
  );

  idea_mul u_mul_t1 (
    .clk_i  (clk_i),
    .en_a_i (en[2]),
    .en_b_i (en[3]),
    .a_i    (e1 ^ s1_e3_q),
    .b_i    (s1_k5_q),
    .prod_o (t1)
  );

  idea_mul u_mul_t2 (
    .clk_i  (clk_i),
    .en_a_i (en[4]),
    .en_b_i (en[5]),
    .a_i    ((s3_e2_q ^ s3_e4_q) + t1),
    .b_i    (s3_k6_q),
    .prod_o (t2)
  );

  always_comb begin
    u    = s5_t1_q + t2;
    y1_d = s5_e1_q ^ t2;
    y2_d = s5_e3_q ^ t2;
    y3_d = s5_e2_q ^ u;
    y4_d = s5_e4_q ^ u;
    case (s5_func_q)
      idea_pkg::TAP_PROD: tap_d = s5_e1_q;
      idea_pkg::TAP_MA1:  tap_d = s5_t1_q;
      default:            tap_d = t2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_func_q <= in_i.func;
      s0_e2_q   <= in_i.x_two + in_i.k_two;
      s0_e3_q   <= in_i.x_three + in_i.k_three;
      s0_k5_q   <= in_i.k_five;
      s0_k6_q   <= in_i.k_six;
    end
    if (en[1]) begin
      s1_func_q <= s0_func_q;
      s1_e2_q   <= s0_e2_q;
      s1_e3_q   <= s0_e3_q;
      s1_k5_q   <= s0_k5_q;
      s1_k6_q   <= s0_k6_q;
    end
    if (en[2]) begin
      s2_func_q <= s1_func_q;
      s2_e1_q   <= e1;
      s2_e2_q   <= s1_e2_q;
      s2_e3_q   <= s1_e3_q;
      s2_e4_q   <= e4;
      s2_k6_q   <= s1_k6_q;
    end
    if (en[3]) begin
      s3_func_q <= s2_func_q;
      s3_e1_q   <= s2_e1_q;
      s3_e2_q   <= s2_e2_q;
      s3_e3_q   <= s2_e3_q;
      s3_e4_q   <= s2_e4_q;
      s3_k6_q   <= s2_k6_q;
    end
    if (en[4]) begin
      s4_func_q <= s3_func_q;
      s4_e1_q   <= s3_e1_q;
      s4_e2_q   <= s3_e2_q;
      s4_e3_q   <= s3_e3_q;
      s4_e4_q   <= s3_e4_q;
      s4_t1_q   <= t1;
    end
    if (en[5]) begin
      s5_func_q <= s4_func_q;
      s5_e1_q   <= s4_e1_q;
      s5_e2_q   <= s4_e2_q;
      s5_e3_q   <= s4_e3_q;
      s5_e4_q   <= s4_e4_q;
      s5_t1_q   <= s4_t1_q;
    end
    if (en[Last]) begin
      y1_q  <= y1_d;
      y2_q  <= y2_d;
      y3_q  <= y3_d;
      y4_q  <= y4_d;
      tap_q <= tap_d;
    end
  end

  assign out_o.valid    = v_q[Last];
  assign out_o.y_one    = y1_q;
  assign out_o.y_two    = y2_q;
  assign out_o.y_three  = y3_q;
  assign out_o.y_four   = y4_q;
  assign out_o.tap_word = tap_q;

endmodule

/* rtl/idea_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the IDEA round pipeline, bound to the top level.
module idea_chk (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  idea_pkg::word_t y_one_i,
  input  idea_pkg::word_t tap_word_i
);

  logic [3:0] cnt_q, cnt_d;
  logic       acc_in, acc_out;

  assign acc_in  = in_valid_i && in_ready_i;
  assign acc_out = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + 4'(acc_in) - 4'(acc_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(y_one_i) && $stable(tap_word_i))
    else $error("result beat changed while stalled");

  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(idea_pkg::NumStages))
    else $error("more beats in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without a matching input beat");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("empty pipeline refuses input");

endmodule

bind idea_round_with_taps idea_chk u_idea_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .y_one_i     (out_o.y_one),
  .tap_word_i  (out_o.tap_word)
);
